FILE: design/kctmm_pkg.sv
// ----------------------------------------------------------------------------
// kctmm_pkg: shared types and constants
// Table sizes, field widths, operation and error codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package kctmm_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = $clog2(ENTRIES);

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	localparam count_t COUNT_MAX  = '1;
	localparam count_t COUNT_ONE  = count_t'(1);
	localparam idx_t   IDX_LAST   = idx_t'(ENTRIES - 1);

	// operation codes
	typedef enum logic {
		OP_INC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_FULL   = 2'd1,
		ERR_ABSENT = 2'd2
	} err_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: design/kctmm_req_if.sv
// ----------------------------------------------------------------------------
// kctmm_req_if: request channel
// Valid/ready channel carrying one counter update (operation and key).
// ----------------------------------------------------------------------------
`default_nettype none

interface kctmm_req_if;
	import kctmm_pkg::*;

	logic valid;
	logic ready;
	op_t  func;
	key_t key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

`default_nettype wire

FILE: design/kctmm_rsp_if.sv
// ----------------------------------------------------------------------------
// kctmm_rsp_if: response channel
// Valid/ready channel carrying the min/max report after each update.
// ----------------------------------------------------------------------------
`default_nettype none

interface kctmm_rsp_if;
	import kctmm_pkg::*;

	logic   valid;
	logic   ready;
	key_t   max_key;
	count_t max_count;
	key_t   min_key;
	count_t min_count;
	logic   table_empty;
	err_t   op_error;

	modport source (output valid, output max_key, output max_count, output min_key,
		output min_count, output table_empty, output op_error, input ready);
	modport sink   (input valid, input max_key, input max_count, input min_key,
		input min_count, input table_empty, input op_error, output ready);
endinterface

`default_nettype wire

FILE: design/keyed_counter_table_min_max.sv
// ----------------------------------------------------------------------------
// keyed_counter_table_min_max: keyed counter table with min/max report
// Increments or decrements the counter of one key per transaction, inserting
// and removing entries, then reports the largest and smallest counters.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+-----------
//  req     | in  | func, key                                        | valid/ready
//  rsp     | out | max_key, max_count, min_key, min_count,          | valid/ready
//          |     | table_empty, op_error                            |
//
// A transaction runs through an accept state, a key lookup over every slot, an
// update, a min/max scan over every slot, then a load of the report; a single
// comparator walks the table slot by slot.
// The report lands in an output register; req is ready again as soon as it
// is loaded, so the next transaction runs while the report waits on rsp.
// A report stalled on rsp holds the sequencer in its final state.
// Reset clears all valid bits at once; keys and counts need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_counter_table_min_max (
	input  wire logic      clk,
	input  wire logic      arst_n,
	kctmm_req_if.sink      req,
	kctmm_rsp_if.source    rsp
);
	import kctmm_pkg::*;

	// sequencer
	state_t state_q, state_d;
	idx_t   idx_q;

	// latched transaction
	op_t  func_q;
	key_t key_q;

	// lookup results
	logic hit_q, free_q;
	idx_t hit_slot_q, free_slot_q;
	err_t err_q;

	// scan accumulators
	logic   any_q;
	key_t   mxk_q, mnk_q;
	count_t mxc_q, mnc_q;

	// table storage
	logic [ENTRIES-1:0] valid_q;
	key_t               key_mem [ENTRIES];
	count_t             count_mem [ENTRIES];

	// output register
	logic rsp_valid_q;

	// slot under the shared comparator
	logic   ent_vld;
	key_t   ent_key;
	count_t ent_cnt;
	logic   last_idx;
	logic   rsp_load;

	assign ent_vld  = valid_q[idx_q];
	assign ent_key  = key_mem[idx_q];
	assign ent_cnt  = count_mem[idx_q];
	assign last_idx = (idx_q == IDX_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (last_idx) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// slot index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_LOOKUP || state_q == ST_SCAN) begin
			idx_q <= last_idx ? '0 : idx_q + idx_t'(1);
		end else begin
			idx_q <= '0;
		end
	end

	// latch transaction and walk the lookup
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q <= req.func;
				key_q  <= req.key;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			ST_LOOKUP: begin
				if (ent_vld && ent_key == key_q && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= idx_q;
				end
				if (!ent_vld && !free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// key and count writes
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			if (func_q == OP_INC) begin
				if (hit_q) begin
					if (count_mem[hit_slot_q] != COUNT_MAX) begin
						count_mem[hit_slot_q] <= count_mem[hit_slot_q] + COUNT_ONE;
					end
				end else if (free_q) begin
					key_mem[free_slot_q]   <= key_q;
					count_mem[free_slot_q] <= COUNT_ONE;
				end
			end else if (hit_q && count_mem[hit_slot_q] > COUNT_ONE) begin
				count_mem[hit_slot_q] <= count_mem[hit_slot_q] - COUNT_ONE;
			end
		end
	end

	// valid bits: set on insert, cleared when a count falls from one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (func_q == OP_INC) begin
				if (!hit_q && free_q) begin
					valid_q[free_slot_q] <= 1'b1;
				end
			end else if (hit_q && count_mem[hit_slot_q] <= COUNT_ONE) begin
				valid_q[hit_slot_q] <= 1'b0;
			end
		end
	end

	// error code and min/max scan
	always_ff @(posedge clk) begin
		case (state_q)
			ST_UPDATE: begin
				if (func_q == OP_INC) begin
					err_q <= (!hit_q && !free_q) ? ERR_FULL : ERR_OK;
				end else begin
					err_q <= hit_q ? ERR_OK : ERR_ABSENT;
				end
				any_q <= 1'b0;
				mxk_q <= '0;
				mxc_q <= '0;
				mnk_q <= '0;
				mnc_q <= '0;
			end
			ST_SCAN: begin
				if (ent_vld) begin
					any_q <= 1'b1;
					// first valid slot seeds both, later ones win only strictly
					if (!any_q || ent_cnt > mxc_q) begin
						mxk_q <= ent_key;
						mxc_q <= ent_cnt;
					end
					if (!any_q || ent_cnt < mnc_q) begin
						mnk_q <= ent_key;
						mnc_q <= ent_cnt;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp.max_key     <= mxk_q;
			rsp.max_count   <= mxc_q;
			rsp.min_key     <= mnk_q;
			rsp.min_count   <= mnc_q;
			rsp.table_empty <= !any_q;
			rsp.op_error    <= err_q;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

`default_nettype wire

FILE: tb/sv/keyed_counter_table_min_max_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_counter_table_min_max_tb: self-checking bench for the counter table
// Drives increment/decrement transactions through the req channel and checks
// every min/max report on rsp against a cycle-free table predictor. Covers a
// directed opening, random fill/drain phases with stalls on both sides, a long
// receiver hold-off, and a final drain with removal and re-insertion of a key.
// ----------------------------------------------------------------------------

module keyed_counter_table_min_max_tb;
	import kctmm_pkg::*;

	localparam int   POOL_SIZE    = 24;
	localparam int   PHASES       = 12;
	localparam int   PHASE_ITEMS  = 110;
	localparam int   LONG_HOLD    = 200;
	localparam int   WATCHDOG     = 2000;
	localparam int   SETTLE       = 3 * (ENTRIES + 3);
	localparam int   MAX_MSGS     = 40;
	localparam key_t FULL_KEY     = 32'hA5A5_A5A5;
	localparam key_t TAIL_KEY     = 32'h5A5A_C3C3;

	typedef struct packed {
		op_t  func;
		key_t key;
	} update_t;

	typedef struct packed {
		key_t   max_key;
		count_t max_count;
		key_t   min_key;
		count_t min_count;
		logic   table_empty;
		err_t   op_error;
	} report_t;

	logic clk;
	logic arst_n;

	kctmm_req_if req ();
	kctmm_rsp_if rsp ();

	keyed_counter_table_min_max u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// predicted table contents
	bit     tbl_valid [ENTRIES];
	key_t   tbl_key   [ENTRIES];
	count_t tbl_count [ENTRIES];

	update_t pending_q[$];
	report_t report_q[$];
	key_t    key_pool [POOL_SIZE];

	bit req_took;
	bit idle_on;
	bit long_hold_req;
	int send_gap;
	int hold_left;
	int quiet_cycles;
	int fail_count;
	int n_reports;
	int n_full;
	int n_absent;
	int n_empty;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// apply one update to the predicted table and form the report
	function automatic report_t apply_update(input op_t op, input key_t k);
		report_t r;
		int      hit;
		int      free_slot;
		bit      any;
		hit       = -1;
		free_slot = -1;
		any       = 1'b0;
		r.max_key     = '0;
		r.max_count   = '0;
		r.min_key     = '0;
		r.min_count   = '0;
		r.op_error    = ERR_OK;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_key[i] == k && hit < 0)
				hit = i;
			if (!tbl_valid[i] && free_slot < 0)
				free_slot = i;
		end
		if (op == OP_INC) begin
			if (hit >= 0) begin
				if (tbl_count[hit] != COUNT_MAX)
					tbl_count[hit] = tbl_count[hit] + 1'b1;
			end else if (free_slot < 0) begin
				r.op_error = ERR_FULL;
			end else begin
				tbl_valid[free_slot] = 1'b1;
				tbl_key[free_slot]   = k;
				tbl_count[free_slot] = COUNT_ONE;
			end
		end else begin
			if (hit < 0)
				r.op_error = ERR_ABSENT;
			else if (tbl_count[hit] <= COUNT_ONE)
				tbl_valid[hit] = 1'b0;
			else
				tbl_count[hit] = tbl_count[hit] - 1'b1;
		end
		// min/max walk, strict compare keeps the lowest slot on ties
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_valid[i]) begin
				if (!any) begin
					any         = 1'b1;
					r.max_key   = tbl_key[i];
					r.max_count = tbl_count[i];
					r.min_key   = tbl_key[i];
					r.min_count = tbl_count[i];
				end else begin
					if (tbl_count[i] > r.max_count) begin
						r.max_key   = tbl_key[i];
						r.max_count = tbl_count[i];
					end
					if (tbl_count[i] < r.min_count) begin
						r.min_key   = tbl_key[i];
						r.min_count = tbl_count[i];
					end
				end
			end
		end
		r.table_empty = !any;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
		input logic [31:0] seen);
		if (seen !== want) begin
			fail_count++;
			if (fail_count <= MAX_MSGS)
				$error("%s: expected 0x%0h, actual 0x%0h", fname, want, seen);
		end
	endtask

	task automatic queue_update(input op_t f, input key_t k);
		update_t u;
		u.func = f;
		u.key  = k;
		pending_q = {pending_q, u};
	endtask

	// one random phase: grow phases lean on increments, others on decrements
	task automatic queue_phase(input int n, input bit grow, input int pool_used);
		int   pick;
		op_t  f;
		key_t k;
		for (int i = 0; i < n; i++) begin
			if (grow)
				f = ($urandom_range(0, 99) < 75) ? OP_INC : OP_DEC;
			else
				f = ($urandom_range(0, 99) < 35) ? OP_INC : OP_DEC;
			pick = $urandom_range(0, 99);
			if (pick < 88)
				k = key_pool[$urandom_range(0, pool_used - 1)];
			else if (pick < 94)
				k = key_t'($urandom);
			else
				k = $urandom_range(0, 1) ? '1 : '0;
			queue_update(f, k);
		end
	endtask

	// hold the sender until every outstanding report has been checked
	task automatic drain_wait();
		while (pending_q.size() != 0 || req.valid || report_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_took) begin
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending_q.size() == 0) begin
				req.valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 5);
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				req.func  <= pending_q[0].func;
				req.key   <= pending_q[0].key;
				void'(pending_q.pop_front());
			end
		end
	end

	// response ready with random stalls and the requested long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 5);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// report checking, prediction and watchdog
	always @(posedge clk) begin
		report_t want;
		report_t seen;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				seen.max_key     = rsp.max_key;
				seen.max_count   = rsp.max_count;
				seen.min_key     = rsp.min_key;
				seen.min_count   = rsp.min_count;
				seen.table_empty = rsp.table_empty;
				seen.op_error    = rsp.op_error;
				if (report_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_MSGS)
						$error("report transaction with no update outstanding");
				end else begin
					want = report_q.pop_front();
					check_field("max_key", want.max_key, seen.max_key);
					check_field("max_count", want.max_count, seen.max_count);
					check_field("min_key", want.min_key, seen.min_key);
					check_field("min_count", want.min_count, seen.min_count);
					check_field("table_empty", want.table_empty, seen.table_empty);
					check_field("op_error", want.op_error, seen.op_error);
				end
			end
			if (req.valid && req.ready) begin
				want = apply_update(req.func, req.key);
				report_q = {report_q, want};
				n_reports++;
				if (want.op_error == ERR_FULL)
					n_full++;
				if (want.op_error == ERR_ABSENT)
					n_absent++;
				if (want.table_empty)
					n_empty++;
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG) begin
					$display("keyed_counter_table_min_max_tb failed");
					$finish;
				end
			end
		end
		req_took <= arst_n && req.valid && req.ready;
	end

	// stimulus sequence
	initial begin
		bit grow;
		req.valid     = 1'b0;
		req.func      = OP_INC;
		req.key       = '0;
		rsp.ready     = 1'b0;
		arst_n        = 1'b0;
		idle_on       = 1'b1;
		long_hold_req = 1'b0;
		foreach (key_pool[i])
			key_pool[i] = key_t'($urandom);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: empty table, edge keys, removal, fill, full, reuse of a slot
		queue_update(OP_DEC, '0);
		queue_update(OP_INC, '0);
		queue_update(OP_INC, '1);
		queue_update(OP_INC, '1);
		queue_update(OP_DEC, '0);
		queue_update(OP_DEC, '1);
		queue_update(OP_DEC, '1);
		for (int i = 0; i < ENTRIES; i++)
			queue_update(OP_INC, key_t'(i));
		queue_update(OP_INC, FULL_KEY);
		queue_update(OP_INC, key_t'(3));
		queue_update(OP_DEC, key_t'(7));
		queue_update(OP_INC, FULL_KEY);
		drain_wait();

		// random phases, pausing for all reports after each one
		for (int p = 0; p < PHASES; p++) begin
			grow = (p % 3) != 2;
			idle_on = (p % 4) != 3 && p != 1 && p != PHASES - 1;
			queue_phase(PHASE_ITEMS, grow, $urandom_range(3, POOL_SIZE));
			if (p == 1)
				long_hold_req = 1'b1;
			drain_wait();
		end

		// empty the table, then insert, remove and re-insert one key
		idle_on = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i])
				repeat (tbl_count[i]) queue_update(OP_DEC, tbl_key[i]);
		queue_update(OP_INC, TAIL_KEY);
		queue_update(OP_INC, TAIL_KEY);
		queue_update(OP_DEC, TAIL_KEY);
		queue_update(OP_DEC, TAIL_KEY);
		queue_update(OP_DEC, TAIL_KEY);
		queue_update(OP_INC, TAIL_KEY);
		drain_wait();
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d updates: %0d inserts into a full table, %0d absent decrements",
			n_reports, n_full, n_absent);
		$display("  %0d reports of an empty table", n_empty);
		if (fail_count == 0 && report_q.size() == 0)
			$display("keyed_counter_table_min_max_tb passed");
		else
			$display("keyed_counter_table_min_max_tb failed");
		$finish;
	end

endmodule
